/* rtl/core/qee_pkg.sv */
// ----------------------------------------------------------------------------
// qee_pkg
// Shared types and constants of the quadrature encoder emulator.
// ----------------------------------------------------------------------------
package qee_pkg;

    localparam int POS_WIDTH  = 8;
    localparam int FREQ_WIDTH = 30;
    localparam int MAG_WIDTH  = 7;
    // Dividend is clock_freq / 4, so two bits fewer than the frequency.
    localparam int QUO_WIDTH  = FREQ_WIDTH - 2;
    localparam int DCNT_WIDTH = $clog2(QUO_WIDTH + 1);
    localparam int DELTA_WIDTH = 10;

    localparam logic [FREQ_WIDTH-1:0] FREQ_RESET = 30'd10000000;

    localparam logic signed [DELTA_WIDTH-1:0] POS_TURN = 10'sd200;
    localparam logic signed [DELTA_WIDTH-1:0] POS_HALF = 10'sd100;
    localparam logic [MAG_WIDTH-1:0] SMALL_MOVE_MAX = 7'd2;

    localparam logic OP_POSITION = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        PH_A_LOW  = 2'd0,
        PH_B_HIGH = 2'd1,
        PH_A_HIGH = 2'd2,
        PH_B_LOW  = 2'd3
    } phase_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } state_t;

    // (pos mod 10) * 4 / 10, with mod 10 done by reciprocal multiply.
    function automatic phase_t small_phase(input logic [POS_WIDTH-1:0] pos);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [7:0]  rem;
        phase_t      ph;
        prod = {8'd0, pos} * 16'd205;
        tens = prod[15:11];
        rem  = pos - 8'(tens) * 8'd10;
        case (rem[3:0])
            4'd0, 4'd1, 4'd2:  ph = PH_A_LOW;
            4'd3, 4'd4:        ph = PH_B_HIGH;
            4'd5, 4'd6, 4'd7:  ph = PH_A_HIGH;
            default:           ph = PH_B_LOW;
        endcase
        return ph;
    endfunction

endpackage

/* rtl/core/qee_if.sv */
// ----------------------------------------------------------------------------
// qee_in_if / qee_out_if
// Valid/ready channels carrying the input items and the result items.
// ----------------------------------------------------------------------------
interface qee_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] position;
    logic       button;

    modport source (output valid, output op, output position, output button, input ready);
    modport sink   (input valid, input op, input position, input button, output ready);
endinterface

interface qee_out_if;
    logic valid;
    logic ready;
    logic out_a;
    logic out_b;
    logic out_button;

    modport source (output valid, output out_a, output out_b, output out_button, input ready);
    modport sink   (input valid, input out_a, input out_b, input out_button, output ready);
endinterface

/* rtl/core/quadrature_encoder_emulator_top.sv */
// ----------------------------------------------------------------------------
// quadrature_encoder_emulator_top
// Quadrature A/B level generator driven by knob positions and clock ticks.
// ----------------------------------------------------------------------------
// A tick, a zero move and a move of one or two steps are completed as they are accepted.
// A move of three or more steps sets a new phase period by dividing
// clock_freq / 4 by the move size in a bit-serial divider that produces one
// quotient bit per cycle: 28 quotient bits, and no new transaction is taken
// until the quotient is in. The result of every transaction goes to an output
// register; while it waits there the input is stalled, unless the result is
// taken in the same cycle as the next item.
module quadrature_encoder_emulator_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    qee_in_if.sink                         item,
    qee_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [qee_pkg::FREQ_WIDTH-1:0] cfg_wdata
);
    import qee_pkg::*;

    state_t                  state_reg, state_next;
    logic [FREQ_WIDTH-1:0]   freq_reg;
    logic [POS_WIDTH-1:0]    last_reg,  last_next;
    logic                    dir_reg,   dir_next;
    logic [COUNT_WIDTH-1:0]  period_reg, period_next;
    logic [COUNT_WIDTH-1:0]  tcnt_reg,  tcnt_next;
    phase_t                  phase_reg, phase_next;
    logic                    a_reg, a_next;
    logic                    b_reg, b_next;
    logic                    ov_reg, ov_next;
    logic                    oa_reg, ob_reg, obtn_reg;

    logic                    accept;
    logic                    div_start;
    logic                    div_done;
    logic [QUO_WIDTH-1:0]    div_quo;
    logic [QUO_WIDTH+COUNT_WIDTH-1:0] quo_ext;
    logic [COUNT_WIDTH-1:0]  quo_sat;

    logic signed [DELTA_WIDTH-1:0] d0, d1, d2, dabs;
    logic [MAG_WIDTH-1:0]    mag;
    logic                    move_zero;
    logic                    move_small;
    logic [COUNT_WIDTH-1:0]  tcnt_inc;
    logic                    drive;

    // Move delta, wrapped into -100..100
    always_comb
    begin
        d0 = $signed({2'b00, item.position}) - $signed({2'b00, last_reg});
        d1 = (d0 < -POS_HALF) ? d0 + POS_TURN : d0;
        d2 = (d1 > POS_HALF) ? d1 - POS_TURN : d1;
        dabs = d2[DELTA_WIDTH-1] ? -d2 : d2;
        mag = dabs[MAG_WIDTH-1:0];
        move_zero  = (d2 == '0);
        move_small = (mag <= SMALL_MOVE_MAX);
    end

    assign tcnt_inc = tcnt_reg + 1'b1;
    assign accept   = item.valid && item.ready;

    assign quo_ext = {{COUNT_WIDTH{1'b0}}, div_quo};
    assign quo_sat = (quo_ext[QUO_WIDTH+COUNT_WIDTH-1:COUNT_WIDTH] != '0)
                   ? '1 : quo_ext[COUNT_WIDTH-1:0];

    // FSM outputs
    always_comb
    begin
        item.ready = (state_reg == ST_IDLE) && (!ov_reg || result.ready);
        div_start  = accept && (item.op == OP_POSITION) && !move_zero && !move_small;
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath state
    always_comb
    begin
        last_next   = last_reg;
        dir_next    = dir_reg;
        period_next = period_reg;
        tcnt_next   = tcnt_reg;
        phase_next  = phase_reg;
        drive       = 1'b0;
        ov_next     = ov_reg;

        if (accept)
        begin
            ov_next = 1'b1;
            if (item.op == OP_POSITION)
            begin
                if (move_zero)
                begin
                    period_next = '0;
                end
                else
                begin
                    dir_next  = !d2[DELTA_WIDTH-1];
                    last_next = item.position;
                    if (move_small)
                    begin
                        phase_next  = small_phase(last_reg);
                        drive       = 1'b1;
                        period_next = '0;
                    end
                end
            end
            else if (period_reg != '0)
            begin
                tcnt_next = tcnt_inc;
                if (tcnt_inc >= period_reg)
                begin
                    tcnt_next  = '0;
                    phase_next = dir_reg ? phase_t'(phase_reg + 2'd1)
                                         : phase_t'(phase_reg - 2'd1);
                    drive      = 1'b1;
                end
            end
        end
        else if (result.ready)
        begin
            ov_next = 1'b0;
        end

        if ((state_reg == ST_DIV) && div_done)
        begin
            period_next = quo_sat;
        end

        a_next = a_reg;
        b_next = b_reg;
        if (drive)
        begin
            unique case (phase_next)
                PH_A_LOW:  a_next = 1'b0;
                PH_B_HIGH: b_next = 1'b1;
                PH_A_HIGH: a_next = 1'b1;
                PH_B_LOW:  b_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            freq_reg   <= FREQ_RESET;
            last_reg   <= '0;
            dir_reg    <= 1'b0;
            period_reg <= '0;
            tcnt_reg   <= '0;
            phase_reg  <= PH_A_LOW;
            a_reg      <= 1'b0;
            b_reg      <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we)
            begin
                freq_reg <= cfg_wdata;
            end
            last_reg   <= last_next;
            dir_reg    <= dir_next;
            period_reg <= period_next;
            tcnt_reg   <= tcnt_next;
            phase_reg  <= phase_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            oa_reg   <= a_next;
            ob_reg   <= b_next;
            obtn_reg <= item.button;
        end
    end

    qee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (freq_reg[FREQ_WIDTH-1:2]),
        .divisor  (mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result.valid      = ov_reg;
    assign result.out_a      = oa_reg;
    assign result.out_b      = ob_reg;
    assign result.out_button = obtn_reg;

endmodule

/* rtl/core/qee_div.sv */
// ----------------------------------------------------------------------------
// qee_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qee_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qee_pkg::QUO_WIDTH-1:0] dividend,
    input  logic [qee_pkg::MAG_WIDTH-1:0] divisor,
    output logic                          done,
    output logic [qee_pkg::QUO_WIDTH-1:0] quotient
);
    import qee_pkg::*;

    logic [QUO_WIDTH-1:0]  dq_reg,  dq_next;
    logic [MAG_WIDTH-1:0]  rem_reg, rem_next;
    logic [MAG_WIDTH-1:0]  dvs_reg;
    logic [DCNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [MAG_WIDTH:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, dq_reg[QUO_WIDTH-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next  = dividend;
            rem_next = '0;
            cnt_next = DCNT_WIDTH'(QUO_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? MAG_WIDTH'(trial - {1'b0, dvs_reg}) : trial[MAG_WIDTH-1:0];
            dq_next   = {dq_reg[QUO_WIDTH-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_WIDTH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

/* tb/sv/quadrature_encoder_emulator_top_tb.sv */
// ----------------------------------------------------------------------------
// quadrature_encoder_emulator_top_tb
// Self-checking bench for the quadrature encoder emulator. Knob moves and
// clock ticks are sent over the item channel in random bursts. A behavioral
// copy of the encoder predicts the A/B/button levels of every transaction,
// and the result channel is checked against it under random backpressure.
// Several clock frequency settings are exercised, the extremes among them.
// ----------------------------------------------------------------------------
module quadrature_encoder_emulator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qee_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] position;
        logic       button;
    } knob_event_t;

    typedef struct {
        logic a;
        logic b;
        logic button;
    } pin_levels_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [FREQ_WIDTH-1:0] cfg_wdata;

    qee_in_if  in_if ();
    qee_out_if out_if ();

    quadrature_encoder_emulator_top #(
        .COUNT_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_if),
        .result    (out_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    knob_event_t knob_events[$];
    pin_levels_t levels_due[$];
    int          mismatches = 0;

    // encoder state mirror
    logic [FREQ_WIDTH-1:0] enc_freq;
    logic [7:0]            enc_last_pos;
    logic                  enc_dir;
    logic [31:0]           enc_period;
    logic [31:0]           enc_tick_cnt;
    phase_t                enc_phase;
    logic                  enc_a;
    logic                  enc_b;

    // sender / receiver pacing
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_left;
    int rx_cycle;
    int long_stall_req  = 0;
    int long_stall_seen = 0;
    int long_stall_left = 0;

    // stimulus generation
    logic [7:0] gen_pos;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void drive_channel();
        case (enc_phase)
            PH_A_LOW:  enc_a = 1'b0;
            PH_B_HIGH: enc_b = 1'b1;
            PH_A_HIGH: enc_a = 1'b1;
            default:   enc_b = 1'b0;
        endcase
    endfunction

    function automatic void step_encoder(input knob_event_t ev);
        int          d;
        int          mag;
        longint      q;
        pin_levels_t lv;
        if (ev.op == OP_POSITION)
        begin
            d = int'(ev.position) - int'(enc_last_pos);
            if (d < -100)
                d += 200;
            if (d > 100)
                d -= 200;
            if (d == 0)
            begin
                enc_period = '0;
            end
            else
            begin
                enc_dir = (d > 0);
                mag = (d > 0) ? d : -d;
                if (mag <= 2)
                begin
                    enc_phase = phase_t'(2'(((int'(enc_last_pos) % 10) * 4) / 10));
                    drive_channel();
                    enc_period = '0;
                end
                else
                begin
                    q = longint'(enc_freq) / (4 * longint'(mag));
                    enc_period = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
                end
                enc_last_pos = ev.position;
            end
        end
        else if (enc_period != 0)
        begin
            enc_tick_cnt = enc_tick_cnt + 32'd1;
            if (enc_tick_cnt >= enc_period)
            begin
                enc_tick_cnt = '0;
                if (enc_dir)
                    enc_phase = phase_t'(enc_phase + 2'd1);
                else
                    enc_phase = phase_t'(enc_phase + 2'd3);
                drive_channel();
            end
        end
        lv.a      = enc_a;
        lv.b      = enc_b;
        lv.button = ev.button;
        levels_due.push_back(lv);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        knob_event_t ev;
        if (!rst_n)
        begin
            in_if.valid    <= 1'b0;
            in_if.op       <= OP_POSITION;
            in_if.position <= '0;
            in_if.button   <= 1'b0;
            burst_left     = 8;
            gap_left       = 0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                ev = knob_events.pop_front();
                step_encoder(ev);
            end
            if (in_if.valid && !in_if.ready)
            begin
                // hold the offered transaction
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_if.valid <= 1'b0;
            end
            else if (knob_events.size() > 0)
            begin
                in_if.valid    <= 1'b1;
                in_if.op       <= knob_events[0].op;
                in_if.position <= knob_events[0].position;
                in_if.button   <= knob_events[0].button;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                        default:    gap_left = $urandom_range(5, 40);
                    endcase
                end
            end
            else
            begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        pin_levels_t want;
        logic        rdy;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            rx_mode  = 0;
            rx_left  = 0;
            rx_cycle = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (levels_due.size() == 0)
                begin
                    $error("unexpected transaction: out_a=%0b out_b=%0b out_button=%0b",
                           out_if.out_a, out_if.out_b, out_if.out_button);
                    mismatches++;
                end
                else
                begin
                    want = levels_due.pop_front();
                    if (out_if.out_a !== want.a)
                    begin
                        $error("out_a: expected %0b, actual %0b", want.a, out_if.out_a);
                        mismatches++;
                    end
                    if (out_if.out_b !== want.b)
                    begin
                        $error("out_b: expected %0b, actual %0b", want.b, out_if.out_b);
                        mismatches++;
                    end
                    if (out_if.out_button !== want.button)
                    begin
                        $error("out_button: expected %0b, actual %0b",
                               want.button, out_if.out_button);
                        mismatches++;
                    end
                end
            end
            if (long_stall_seen != long_stall_req)
            begin
                long_stall_seen = long_stall_req;
                long_stall_left = 400;
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 200);
            end
            else
            begin
                rx_left--;
            end
            rx_cycle++;
            if (long_stall_left > 0)
            begin
                long_stall_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 9) != 0);
                    default: rdy = ((rx_cycle % 7) < 3);
                endcase
            end
            out_if.ready <= rdy;
        end
    end

    task automatic push_event(input logic op, input int pos, input logic btn);
        knob_event_t ev;
        ev.op       = op;
        ev.position = 8'(pos);
        ev.button   = btn;
        knob_events.push_back(ev);
    endtask

    task automatic push_move(input int delta);
        int p;
        p = (int'(gen_pos) + delta) % 200;
        if (p < 0)
            p += 200;
        gen_pos = 8'(p);
        push_event(OP_POSITION, p, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        while (knob_events.size() != 0 || levels_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_freq(input logic [FREQ_WIDTH-1:0] value);
        wait_drained();
        while (!in_if.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        enc_freq  = value;
        @(negedge clk);
    endtask

    task automatic random_run(input int count);
        int n;
        int k;
        int mag;
        n = 0;
        while (n < count)
        begin
            k = $urandom_range(0, 99);
            if (k < 8)
            begin
                push_event(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                           1'($urandom_range(0, 1)));
                n++;
            end
            else
            begin
                k = $urandom_range(0, 9);
                if (k < 3)
                begin
                    mag = $urandom_range(1, 2);
                    push_move($urandom_range(0, 1) ? mag : -mag);
                end
                else if (k < 8)
                begin
                    mag = $urandom_range(3, 100);
                    push_move($urandom_range(0, 1) ? mag : -mag);
                end
                else if (k < 9)
                begin
                    push_move(0);
                end
                else
                begin
                    gen_pos = 8'($urandom_range(200, 255));
                    push_event(OP_POSITION, gen_pos, 1'($urandom_range(0, 1)));
                end
                n++;
                k = $urandom_range(0, 40);
                repeat (k)
                begin
                    push_event(OP_TICK, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        #1500000;
        $display("quadrature_encoder_emulator_top_tb failed");
        $finish;
    end

    initial
    begin
        int i;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_if.valid    = 1'b0;
        in_if.op       = OP_POSITION;
        in_if.position = '0;
        in_if.button   = 1'b0;
        out_if.ready   = 1'b0;

        enc_freq     = FREQ_RESET;
        enc_last_pos = '0;
        enc_dir      = 1'b0;
        enc_period   = '0;
        enc_tick_cnt = '0;
        enc_phase    = PH_A_LOW;
        enc_a        = 1'b0;
        enc_b        = 1'b0;
        gen_pos      = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: wrap, small and large moves, out-of-range positions
        push_event(OP_TICK,     0,   1'b0);   // idle tick
        push_event(OP_POSITION, 0,   1'b1);   // zero move
        push_event(OP_POSITION, 1,   1'b0);
        push_event(OP_POSITION, 3,   1'b1);
        push_event(OP_POSITION, 2,   1'b0);
        push_event(OP_POSITION, 0,   1'b1);
        push_event(OP_POSITION, 199, 1'b0);   // -1 across the wrap
        push_event(OP_POSITION, 1,   1'b1);   // +2 across the wrap
        push_event(OP_POSITION, 101, 1'b0);   // +100
        push_event(OP_TICK,     255, 1'b1);
        push_event(OP_POSITION, 1,   1'b0);   // -100
        push_event(OP_POSITION, 4,   1'b1);   // +3
        push_event(OP_POSITION, 255, 1'b0);
        push_event(OP_POSITION, 200, 1'b1);
        push_event(OP_POSITION, 0,   1'b0);   // wraps to zero move
        push_event(OP_POSITION, 201, 1'b1);   // small from out of range
        wait_drained();

        write_freq('0);
        push_event(OP_POSITION, 50,  1'b0);
        push_event(OP_TICK,     0,   1'b1);

        write_freq({FREQ_WIDTH{1'b1}});
        push_event(OP_POSITION, 150, 1'b1);
        push_event(OP_POSITION, 153, 1'b0);
        push_event(OP_TICK,     0,   1'b1);

        write_freq(30'd12);
        push_event(OP_POSITION, 156, 1'b0);   // period 1, stepping up
        for (i = 0; i < 5; i++)
            push_event(OP_TICK, 0, 1'(i));
        push_event(OP_POSITION, 153, 1'b1);   // stepping down
        for (i = 0; i < 5; i++)
            push_event(OP_TICK, 0, 1'(i));
        wait_drained();
        gen_pos = enc_last_pos;

        write_freq(30'd60);
        random_run(150);

        write_freq(30'd1);
        random_run(100);

        write_freq(30'd200);
        long_stall_req++;
        random_run(150);

        write_freq(30'($urandom_range(12, 800)));
        random_run(80);
        wait_drained();
        random_run(80);

        write_freq(30'd24);
        random_run(150);

        write_freq({FREQ_WIDTH{1'b1}});
        random_run(40);

        write_freq(30'($urandom_range(100, 1000)));
        random_run(150);

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("quadrature_encoder_emulator_top_tb passed");
        else
            $display("quadrature_encoder_emulator_top_tb failed");
        $finish;
    end

endmodule
